// ===== sv/rsr_pkg.sv =====
`default_nettype none

package rsr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COORD_BITS  = 12;
    localparam int CENTER_BITS = 20;
    localparam int COEF_FRAC   = 30;
    localparam int DIV_STAGES  = COEF_FRAC + 1;
    localparam int PIPE_DEPTH  = DIV_STAGES + 8;
    localparam int NUM_BITS    = 34;
    localparam int DEN_BITS    = 33;
    localparam int PROD_BITS   = SAMPLE_BITS + 32;
    localparam int SUM_BITS    = PROD_BITS + 1;

    localparam logic [CENTER_BITS-1:0] CENTER_RESET = 20'd256;

    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] q;
        logic signed [SAMPLE_BITS-1:0] u;
        logic                          c_neg;
        logic                          s_neg;
        logic                          zero;
    } side_t;

    // round to nearest (ties away from zero) by 2^COEF_FRAC, then saturate
    function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic [SUM_BITS-1:0] v);
        logic [SUM_BITS-1:0] neg_v;
        logic [SUM_BITS-1:0] m;
        logic [SUM_BITS-1:0] rnd;
        logic [SUM_BITS-COEF_FRAC-1:0] r;
        logic [SUM_BITS-COEF_FRAC-1:0] lim;
        logic [SAMPLE_BITS-1:0] rl;
        neg_v = -v;
        m     = v[SUM_BITS-1] ? neg_v : v;
        rnd   = m + (SUM_BITS'(1) << (COEF_FRAC - 1));
        r     = rnd[SUM_BITS-1:COEF_FRAC];
        lim   = (SUM_BITS-COEF_FRAC)'(1) << (SAMPLE_BITS - 1);
        rl    = r[SAMPLE_BITS-1:0];
        if (v[SUM_BITS-1])
        begin
            if (r > lim)
            begin
                return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
            return -rl;
        end
        if (r >= lim)
        begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return rl;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rsr_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per stage; num/den <= 1 assumed
module rsr_div (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [rsr_pkg::NUM_BITS-1:0]       num,
    input  wire logic [rsr_pkg::DEN_BITS-1:0]       den,
    output logic      [rsr_pkg::DIV_STAGES-1:0]     quot,
    output logic      [rsr_pkg::NUM_BITS-1:0]       rem,
    output logic      [rsr_pkg::DEN_BITS-1:0]       den_out
);

    logic [rsr_pkg::NUM_BITS-1:0]   rem_reg  [rsr_pkg::DIV_STAGES];
    logic [rsr_pkg::DIV_STAGES-1:0] quot_reg [rsr_pkg::DIV_STAGES];
    logic [rsr_pkg::DEN_BITS-1:0]   den_reg  [rsr_pkg::DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < rsr_pkg::DIV_STAGES; k++)
        begin : g_stage
            logic [rsr_pkg::NUM_BITS-1:0]   r_in;
            logic [rsr_pkg::DEN_BITS-1:0]   d_in;
            logic [rsr_pkg::DIV_STAGES-1:0] q_in;
            logic                           bit_q;
            if (k == 0)
            begin : g_first
                assign r_in = num;
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = {rem_reg[k-1][rsr_pkg::NUM_BITS-2:0], 1'b0};
                assign d_in = den_reg[k-1];
                assign q_in = quot_reg[k-1];
            end
            assign bit_q = r_in >= {1'b0, d_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= bit_q ? r_in - {1'b0, d_in} : r_in;
                    quot_reg[k] <= {q_in[rsr_pkg::DIV_STAGES-2:0], bit_q};
                    den_reg[k]  <= d_in;
                end
            end
        end
    endgenerate

    assign quot    = quot_reg[rsr_pkg::DIV_STAGES-1];
    assign rem     = rem_reg[rsr_pkg::DIV_STAGES-1];
    assign den_out = den_reg[rsr_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/radial_stokes_rotation.sv =====
// Throughput: one request per cycle; the whole pipeline holds while a result is not taken.
// Coefficients cos/sin(2t) come from two 31-stage restoring dividers run in parallel.
// Reset (rst_n low, asynchronous): pipeline emptied, center_x and center_y set to 1.0.
`default_nettype none

module radial_stokes_rotation (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [rsr_pkg::COORD_BITS-1:0]      pixel_col,
    input  wire logic [rsr_pkg::COORD_BITS-1:0]      pixel_row,
    input  wire logic signed [rsr_pkg::SAMPLE_BITS-1:0] q_in,
    input  wire logic signed [rsr_pkg::SAMPLE_BITS-1:0] u_in,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [rsr_pkg::SAMPLE_BITS-1:0]   q_out,
    output logic signed [rsr_pkg::SAMPLE_BITS-1:0]   u_out
);

    localparam int SB = rsr_pkg::SAMPLE_BITS;
    localparam int COEF_IDX = rsr_pkg::DIV_STAGES + 4;

    logic [rsr_pkg::CENTER_BITS-1:0] center_x_reg;
    logic [rsr_pkg::CENTER_BITS-1:0] center_y_reg;
    logic [rsr_pkg::PIPE_DEPTH-1:0]  valid_reg;
    logic                            adv;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= rsr_pkg::CENTER_RESET;
            center_y_reg <= rsr_pkg::CENTER_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == rsr_pkg::REG_CENTER_X)
            begin
                center_x_reg <= pwdata[rsr_pkg::CENTER_BITS-1:0];
            end
            else
            begin
                center_y_reg <= pwdata[rsr_pkg::CENTER_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            rsr_pkg::REG_CENTER_X: prdata = {12'd0, center_x_reg};
            rsr_pkg::REG_CENTER_Y: prdata = {12'd0, center_y_reg};
            default:               prdata = '0;
        endcase
    end

    // pipeline control
    assign adv      = !valid_reg[rsr_pkg::PIPE_DEPTH-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = valid_reg[rsr_pkg::PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[rsr_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    // stage 1: offsets from center, 1/256 pixel units
    logic signed [21:0]   dx_reg, dy_reg;
    logic signed [SB-1:0] q1_reg, u1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= $signed({2'b00, pixel_col, 8'h00}) + 22'sd256
                      - $signed({2'b00, center_x_reg});
            dy_reg <= $signed({2'b00, pixel_row, 8'h00}) + 22'sd256
                      - $signed({2'b00, center_y_reg});
            q1_reg <= q_in;
            u1_reg <= u_in;
        end
    end

    // stage 2: magnitudes, normalized below 2^16
    logic [21:0] dx_neg, dy_neg;
    logic [20:0] ax, ay, any_bits, ax_sh, ay_sh;
    logic [2:0]  sh;
    logic [15:0] a_reg, b_reg;
    logic        sa_reg, sb_reg;
    logic signed [SB-1:0] q2_reg, u2_reg;

    always_comb
    begin
        dx_neg   = -dx_reg;
        dy_neg   = -dy_reg;
        ax       = dx_reg[21] ? dx_neg[20:0] : dx_reg[20:0];
        ay       = dy_reg[21] ? dy_neg[20:0] : dy_reg[20:0];
        any_bits = ax | ay;
        if (any_bits[20])      sh = 3'd5;
        else if (any_bits[19]) sh = 3'd4;
        else if (any_bits[18]) sh = 3'd3;
        else if (any_bits[17]) sh = 3'd2;
        else if (any_bits[16]) sh = 3'd1;
        else                   sh = 3'd0;
        ax_sh = ax >> sh;
        ay_sh = ay >> sh;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= ax_sh[15:0];
            b_reg  <= ay_sh[15:0];
            sa_reg <= dx_reg[21];
            sb_reg <= dy_reg[21];
            q2_reg <= q1_reg;
            u2_reg <= u1_reg;
        end
    end

    // stage 3: squares and cross product
    logic [31:0] a2_reg, b2_reg, ab_reg;
    logic        s_neg3_reg;
    logic signed [SB-1:0] q3_reg, u3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg     <= a_reg * a_reg;
            b2_reg     <= b_reg * b_reg;
            ab_reg     <= a_reg * b_reg;
            s_neg3_reg <= sa_reg ^ sb_reg;
            q3_reg     <= q2_reg;
            u3_reg     <= u2_reg;
        end
    end

    // stage 4: numerators and r^2
    logic [rsr_pkg::NUM_BITS-1:0] cnum_reg, snum_reg;
    logic [rsr_pkg::DEN_BITS-1:0] r2_reg;
    rsr_pkg::side_t               side4_reg;
    logic                         c_neg4;
    logic [31:0]                  cdiff;

    always_comb
    begin
        c_neg4 = b2_reg > a2_reg;
        cdiff  = c_neg4 ? b2_reg - a2_reg : a2_reg - b2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cnum_reg        <= {2'b00, cdiff};
            snum_reg        <= {1'b0, ab_reg, 1'b0};
            r2_reg          <= {1'b0, a2_reg} + {1'b0, b2_reg};
            side4_reg.q     <= q3_reg;
            side4_reg.u     <= u3_reg;
            side4_reg.c_neg <= c_neg4;
            side4_reg.s_neg <= s_neg3_reg;
            side4_reg.zero  <= (a2_reg == 32'd0) && (b2_reg == 32'd0);
        end
    end

    // dividers
    logic [rsr_pkg::DIV_STAGES-1:0] quot_c, quot_s;
    logic [rsr_pkg::NUM_BITS-1:0]   rem_c, rem_s;
    logic [rsr_pkg::DEN_BITS-1:0]   den_c, den_s;

    rsr_div u_div_c (
        .clk     (clk),
        .en      (adv),
        .num     (cnum_reg),
        .den     (r2_reg),
        .quot    (quot_c),
        .rem     (rem_c),
        .den_out (den_c)
    );

    rsr_div u_div_s (
        .clk     (clk),
        .en      (adv),
        .num     (snum_reg),
        .den     (r2_reg),
        .quot    (quot_s),
        .rem     (rem_s),
        .den_out (den_s)
    );

    rsr_pkg::side_t side_reg [rsr_pkg::DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side4_reg;
            for (int i = 1; i < rsr_pkg::DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // coefficient stage: round quotient, apply sign, center override
    rsr_pkg::side_t side_d;
    logic [rsr_pkg::DIV_STAGES-1:0] cmag, smag;
    logic signed [31:0] c_val, s_val;
    logic signed [31:0] c_reg, s_reg;
    logic signed [SB-1:0] q5_reg, u5_reg;

    always_comb
    begin
        side_d = side_reg[rsr_pkg::DIV_STAGES-1];
        cmag = quot_c + rsr_pkg::DIV_STAGES'({rem_c, 1'b0} >= {2'b00, den_c});
        smag = quot_s + rsr_pkg::DIV_STAGES'({rem_s, 1'b0} >= {2'b00, den_s});
        c_val = side_d.c_neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
        s_val = side_d.s_neg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
        if (side_d.zero)
        begin
            c_val = 32'sd1 <<< rsr_pkg::COEF_FRAC;
            s_val = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg  <= c_val;
            s_reg  <= s_val;
            q5_reg <= side_d.q;
            u5_reg <= side_d.u;
        end
    end

    // products
    logic signed [rsr_pkg::PROD_BITS-1:0] pqc_reg, pus_reg, puc_reg, pqs_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pqc_reg <= q5_reg * c_reg;
            pus_reg <= u5_reg * s_reg;
            puc_reg <= u5_reg * c_reg;
            pqs_reg <= q5_reg * s_reg;
        end
    end

    // sums
    logic signed [rsr_pkg::SUM_BITS-1:0] sq_reg, su_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= rsr_pkg::SUM_BITS'(pqc_reg) + rsr_pkg::SUM_BITS'(pus_reg);
            su_reg <= rsr_pkg::SUM_BITS'(puc_reg) - rsr_pkg::SUM_BITS'(pqs_reg);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_out <= rsr_pkg::round_sat(sq_reg);
            u_out <= rsr_pkg::round_sat(su_reg);
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline valids moved during stall");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[COEF_IDX] |-> (c_reg <= (32'sd1 <<< rsr_pkg::COEF_FRAC)
                                 && c_reg >= -(32'sd1 <<< rsr_pkg::COEF_FRAC)
                                 && s_reg <= (32'sd1 <<< rsr_pkg::COEF_FRAC)
                                 && s_reg >= -(32'sd1 <<< rsr_pkg::COEF_FRAC)))
        else $error("rotation coefficient out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted request lost at pipeline entry");

endmodule

`default_nettype wire

// ===== tb/sv/rsr_checker.sv =====
module rsr_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [2:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    input  wire logic                                  pready,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_ready,
    input  wire logic [rsr_pkg::COORD_BITS-1:0]        pixel_col,
    input  wire logic [rsr_pkg::COORD_BITS-1:0]        pixel_row,
    input  wire logic signed [rsr_pkg::SAMPLE_BITS-1:0] q_in,
    input  wire logic signed [rsr_pkg::SAMPLE_BITS-1:0] u_in,
    input  wire logic                                  out_valid,
    input  wire logic                                  out_ready,
    input  wire logic signed [rsr_pkg::SAMPLE_BITS-1:0] q_out,
    input  wire logic signed [rsr_pkg::SAMPLE_BITS-1:0] u_out,
    output int                                         errors,
    output int                                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rsr_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] q;
        logic signed [SAMPLE_BITS-1:0] u;
    } qu_pair_t;

    localparam int CF = COEF_FRAC;

    logic [CENTER_BITS-1:0] ctr_x, ctr_y;
    qu_pair_t rotated_q[$];

    function automatic longint coef_div(longint num, longint den);
        longint n, q, r;
        n = (num < 0 ? -num : num) << CF;
        q = n / den;
        r = n % den;
        if (r >= den - r)
            q++;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint sat_round(longint v);
        longint m, hi;
        m  = ((v < 0 ? -v : v) + (longint'(1) << (CF - 1))) >>> CF;
        m  = v < 0 ? -m : m;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (m > hi) m = hi;
        if (m < -hi - 1) m = -hi - 1;
        return m;
    endfunction

    function automatic qu_pair_t rotate_pixel(logic [COORD_BITS-1:0] col,
                                              logic [COORD_BITS-1:0] row,
                                              logic signed [SAMPLE_BITS-1:0] qv,
                                              logic signed [SAMPLE_BITS-1:0] uv);
        longint dx, dy, ax, ay, a, b, c, s, r2, qq, uu;
        qu_pair_t res;
        dx = longint'(col) * 256 + 256 - longint'(ctr_x);
        dy = longint'(row) * 256 + 256 - longint'(ctr_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        while (ax >= 65536 || ay >= 65536)
        begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        if (ax == 0 && ay == 0)
        begin
            c = longint'(1) << CF;
            s = 0;
        end
        else
        begin
            a  = dx < 0 ? -ax : ax;
            b  = dy < 0 ? -ay : ay;
            r2 = ax * ax + ay * ay;
            c  = coef_div(a * a - b * b, r2);
            s  = coef_div(2 * a * b, r2);
        end
        qq = qv;
        uu = uv;
        res.q = SAMPLE_BITS'(sat_round(qq * c + uu * s));
        res.u = SAMPLE_BITS'(sat_round(uu * c - qq * s));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    assign pending = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        qu_pair_t want;
        if (!rst_n)
        begin
            ctr_x  <= CENTER_RESET;
            ctr_y  <= CENTER_RESET;
            errors = 0;
            rotated_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_CENTER_X)
                    ctr_x <= pwdata[CENTER_BITS-1:0];
                else
                    ctr_y <= pwdata[CENTER_BITS-1:0];
            end
            if (in_valid && in_ready)
                rotated_q.push_back(rotate_pixel(pixel_col, pixel_row, q_in, u_in));
            if (out_valid && out_ready)
            begin
                if (rotated_q.size() == 0)
                    report_mismatch("unexpected result q_out", q_out, 0);
                else
                begin
                    want = rotated_q.pop_front();
                    if (q_out !== want.q)
                        report_mismatch("q_out", q_out, want.q);
                    if (u_out !== want.u)
                        report_mismatch("u_out", u_out, want.u);
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsr_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic [COORD_BITS-1:0] pixel_col = '0, pixel_row = '0;
    logic signed [SAMPLE_BITS-1:0] q_in = '0, u_in = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] q_out, u_out;
    int errors, pending;
    int cycles = 0;
    bit hold_off = 0;

    localparam int CYCLE_LIMIT = 200000;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    radial_stokes_rotation dut (.*);

    rsr_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic write_center(logic idx, logic [19:0] val);
        @(negedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row,
                              logic [23:0] qv, logic [23:0] uv);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        q_in      <= qv;
        u_in      <= uv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_sample;
        case ($urandom_range(0, 4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 4096)) - 24'd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0)
                w = 0;
            if (w != 0)
            begin
                out_ready <= 1'b0;
                repeat (w - 1) @(negedge clk);
                @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [19:0] cx [5];
        logic [19:0] cy [5];
        logic [11:0] ccol, crow;
        cx = '{20'd256, 20'd0, 20'hFFFFF, 20'd524416, 20'd12345};
        cy = '{20'd256, 20'hFFFFF, 20'd0, 20'd524416, 20'd700000};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // centre pixel at reset config, extremes, overflow
        send_pixel(12'd0, 12'd0, 24'h123456, 24'hFEDCBA);
        send_pixel(12'd0, 12'd0, 24'h7FFFFF, 24'h800000);
        send_pixel(12'd1, 12'd1, 24'h7FFFFF, 24'h7FFFFF);
        send_pixel(12'd1, 12'd1, 24'h800000, 24'h800000);
        send_pixel(12'd0, 12'd5, 24'h7FFFFF, 24'h800000);
        send_pixel(12'd5, 12'd0, 24'h800000, 24'h7FFFFF);
        send_pixel(12'hFFF, 12'hFFF, 24'h7FFFFF, 24'h000001);
        send_pixel(12'hFFF, 12'd0, 24'hFFFFFF, 24'h400000);
        send_pixel(12'd0, 12'hFFF, 24'h000000, 24'h7FFFFF);
        send_pixel(12'hAAA, 12'h555, 24'hAAAAAA, 24'h555555);
        send_pixel(12'h555, 12'hAAA, 24'h555555, 24'hAAAAAA);
        send_pixel(12'd3, 12'd3, 24'h800000, 24'h7FFFFF);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_center(REG_CENTER_X, cx[ph]);
            write_center(REG_CENTER_Y, cy[ph]);
            ccol = 12'((cx[ph] >> 8) - 1);
            crow = 12'((cy[ph] >> 8) - 1);
            send_pixel(ccol, crow, 24'h7FFFFF, 24'h800000);
            if (ph == 2)
                hold_off = 1;
            for (int i = 0; i < 220; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(ccol + 12'($urandom_range(0, 2)) - 12'd1,
                               crow + 12'($urandom_range(0, 2)) - 12'd1,
                               rand_sample(), rand_sample());
                else
                    send_pixel(12'($urandom), 12'($urandom), rand_sample(), rand_sample());
            end
        end
        drain();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
